[rtl/srn_pkg.sv]
// ----------------------------------------------------------------------------
// srn_pkg
// Shared types and constants of the spike response neuron step block.
// ----------------------------------------------------------------------------
`default_nettype none

package srn_pkg;

  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned CfgIdxWidth  = 3;

  localparam logic [CfgIdxWidth-1:0] RegDecayExc       = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegDecayInh       = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegGainExc        = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegGainInh        = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegDecayAfterSpk  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegResetDepth     = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegRefractTicks   = 3'd6;
  localparam logic [CfgIdxWidth-1:0] RegFlushOnFire    = 3'd7;

  localparam logic [15:0] DecayExcRst      = 16'd64769;
  localparam logic [15:0] DecayInhRst      = 16'd64769;
  localparam logic [19:0] GainExcRst       = 20'd1595;
  localparam logic [19:0] GainInhRst       = 20'd1595;
  localparam logic [15:0] DecayAfterSpkRst = 16'd65112;
  localparam logic [19:0] ResetDepthRst    = 20'd151388;
  localparam logic [15:0] RefractTicksRst  = 16'd20;
  localparam logic        FlushOnFireRst   = 1'b0;

  localparam logic signed [31:0] ThresholdQ16 = 32'sd65536;

  typedef struct packed {
    logic        [30:0] exc_weight;
    logic signed [31:0] inh_weight;
    logic signed [31:0] noise_sample;
    logic signed [31:0] inhibit_potential;
  } in_payload_t;

  typedef struct packed {
    logic               spike;
    logic signed [31:0] membrane;
    logic               refractory;
  } out_payload_t;

endpackage

`default_nettype wire

[rtl/srn_if.sv]
// ----------------------------------------------------------------------------
// srn_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface srn_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/spike_response_neuron_step.sv]
// ----------------------------------------------------------------------------
// spike_response_neuron_step
// One simulation tick of a spike response neuron per input beat, Q16.16.
// ----------------------------------------------------------------------------
// Path: input register, then result register, from input beat to result beat;
//   the neuron state updates in the same cycle as the result.
// Throughput: one beat per cycle while out_o is ready; the state update loop
//   through the multipliers and saturating adders sets this figure.
// Reset: state clears to zero, registers load their defaults, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_response_neuron_step (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  srn_if.sink                                      in_i,
  srn_if.source                                    out_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [srn_pkg::CfgAddrWidth-1:0]    paddr,
  input  wire logic [srn_pkg::CfgDataWidth-1:0]    pwdata,
  output logic      [srn_pkg::CfgDataWidth-1:0]    prdata,
  output logic                                     pready
);

  function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [15:0] decay_exc_q, decay_inh_q, decay_as_q, refr_ticks_q;
  logic [19:0] gain_exc_q, gain_inh_q, reset_depth_q;
  logic        flush_q;
  logic        cfg_wr;
  logic [srn_pkg::CfgIdxWidth-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[srn_pkg::CfgAddrWidth-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_exc_q   <= srn_pkg::DecayExcRst;
      decay_inh_q   <= srn_pkg::DecayInhRst;
      gain_exc_q    <= srn_pkg::GainExcRst;
      gain_inh_q    <= srn_pkg::GainInhRst;
      decay_as_q    <= srn_pkg::DecayAfterSpkRst;
      reset_depth_q <= srn_pkg::ResetDepthRst;
      refr_ticks_q  <= srn_pkg::RefractTicksRst;
      flush_q       <= srn_pkg::FlushOnFireRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        srn_pkg::RegDecayExc:      decay_exc_q   <= pwdata[15:0];
        srn_pkg::RegDecayInh:      decay_inh_q   <= pwdata[15:0];
        srn_pkg::RegGainExc:       gain_exc_q    <= pwdata[19:0];
        srn_pkg::RegGainInh:       gain_inh_q    <= pwdata[19:0];
        srn_pkg::RegDecayAfterSpk: decay_as_q    <= pwdata[15:0];
        srn_pkg::RegResetDepth:    reset_depth_q <= pwdata[19:0];
        srn_pkg::RegRefractTicks:  refr_ticks_q  <= pwdata[15:0];
        srn_pkg::RegFlushOnFire:   flush_q       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      srn_pkg::RegDecayExc:      prdata = {16'd0, decay_exc_q};
      srn_pkg::RegDecayInh:      prdata = {16'd0, decay_inh_q};
      srn_pkg::RegGainExc:       prdata = {12'd0, gain_exc_q};
      srn_pkg::RegGainInh:       prdata = {12'd0, gain_inh_q};
      srn_pkg::RegDecayAfterSpk: prdata = {16'd0, decay_as_q};
      srn_pkg::RegResetDepth:    prdata = {12'd0, reset_depth_q};
      srn_pkg::RegRefractTicks:  prdata = {16'd0, refr_ticks_q};
      srn_pkg::RegFlushOnFire:   prdata = {31'd0, flush_q};
      default:                   prdata = '0;
    endcase
  end

  // input register and handshake
  srn_pkg::in_payload_t  in_q;
  srn_pkg::out_payload_t out_q, out_d;
  logic                  in_valid_q, out_valid_q, adv;

  assign adv        = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~in_valid_q | adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  // neuron state
  logic signed [31:0] ce_q, ci_q, sp_q, asp_q, mem_q;
  logic signed [31:0] ce_d, ci_d, sp_d, asp_d, mem_d;
  logic        [15:0] refr_q, refr_d;

  logic signed [48:0] sp_dec_p, ce_dec_p, ci_dec_p, asp_dec_p;
  logic signed [52:0] ce_gain_p, ci_gain_p;
  logic signed [37:0] sp_sum, ce_sum, ci_sum, mem_sum;
  logic signed [31:0] sp_new, ce_new, ci_new, asp_new, mem_new, neg_reset;
  logic               fire;

  assign sp_dec_p  = sp_q  * $signed({1'b0, decay_exc_q});
  assign ce_dec_p  = ce_q  * $signed({1'b0, decay_exc_q});
  assign ci_dec_p  = ci_q  * $signed({1'b0, decay_inh_q});
  assign asp_dec_p = asp_q * $signed({1'b0, decay_as_q});
  assign ce_gain_p = ce_q  * $signed({1'b0, gain_exc_q});
  assign ci_gain_p = ci_q  * $signed({1'b0, gain_inh_q});

  assign neg_reset = -$signed({12'd0, reset_depth_q});

  always_comb begin
    sp_sum  = {{6{sp_dec_p[47]}}, sp_dec_p[47:16]}
            + {{2{ce_gain_p[51]}}, ce_gain_p[51:16]}
            + {{2{ci_gain_p[51]}}, ci_gain_p[51:16]};
    sp_new  = sat38(sp_sum);
    ce_sum  = {{6{ce_dec_p[47]}}, ce_dec_p[47:16]} + {7'd0, in_q.exc_weight};
    ce_new  = sat38(ce_sum);
    ci_sum  = {{6{ci_dec_p[47]}}, ci_dec_p[47:16]}
            + {{6{in_q.inh_weight[31]}}, in_q.inh_weight};
    ci_new  = sat38(ci_sum);
    asp_new = asp_dec_p[47:16];
    mem_sum = {{6{sp_new[31]}}, sp_new}
            + {{6{asp_new[31]}}, asp_new}
            + {{6{in_q.noise_sample[31]}}, in_q.noise_sample}
            + {{6{in_q.inhibit_potential[31]}}, in_q.inhibit_potential};

    if (refr_q == 16'd0) begin
      mem_new = sat38(mem_sum);
      refr_d  = refr_q;
    end else begin
      mem_new = mem_q;
      refr_d  = refr_q - 16'd1;
    end

    fire  = (mem_new >= srn_pkg::ThresholdQ16);
    sp_d  = sp_new;
    ce_d  = ce_new;
    ci_d  = ci_new;
    asp_d = asp_new;
    mem_d = mem_new;
    if (fire) begin
      refr_d = refr_ticks_q;
      asp_d  = neg_reset;
      mem_d  = neg_reset;
      if (flush_q) begin
        sp_d = '0;
        ce_d = '0;
        ci_d = '0;
      end
    end

    out_d.spike      = fire;
    out_d.membrane   = mem_d;
    out_d.refractory = (refr_d != 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ce_q   <= '0;
      ci_q   <= '0;
      sp_q   <= '0;
      asp_q  <= '0;
      mem_q  <= '0;
      refr_q <= '0;
    end else if (adv) begin
      ce_q   <= ce_d;
      ci_q   <= ci_d;
      sp_q   <= sp_d;
      asp_q  <= asp_d;
      mem_q  <= mem_d;
      refr_q <= refr_d;
    end
  end

  a_spike_resets_membrane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.spike |-> out_q.membrane == neg_reset && asp_q == neg_reset)
    else $error("spike without membrane reset");

  a_spike_loads_refractory: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && fire |=> refr_q == refr_ticks_q && out_q.refractory == (refr_ticks_q != 16'd0))
    else $error("spike did not load refractory count");

  a_refractory_freezes_membrane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && refr_q != 16'd0 && !fire |=> mem_q == $past(mem_q))
    else $error("membrane moved while refractory");

  a_state_holds_without_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(mem_q) && $stable(refr_q) && $stable(ce_q))
    else $error("state changed without a tick");

endmodule

`default_nettype wire
